/* src/airfoil_contour_point_generator_unit_assert.svh */
// Assertion helpers for the airfoil contour point generator.
// Each macro expects clk and rst_n in scope.
`ifndef AIRFOIL_CONTOUR_POINT_GENERATOR_UNIT_ASSERT_SVH
`define AIRFOIL_CONTOUR_POINT_GENERATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACPG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/acpg_pkg.sv */
`default_nettype none
package acpg_pkg;

  // Widths of the datapath.
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned PH_W  = 33;
  localparam int unsigned Q30_W = 31;

  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0]      PI_Q30  = 32'd3373259426;

  // Taylor divisors of the cosine, with reciprocals scaled so each fits 32 bits.
  localparam int unsigned HORNER_STEPS = 7;
  localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{182, 132, 90, 56, 30, 12, 2};
  localparam int unsigned HORNER_SH  [HORNER_STEPS] = '{39, 39, 38, 37, 36, 35, 32};
  localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
    32'((64'd1 << 39) / 64'd182),
    32'((64'd1 << 39) / 64'd132),
    32'((64'd1 << 38) / 64'd90),
    32'((64'd1 << 37) / 64'd56),
    32'((64'd1 << 36) / 64'd30),
    32'((64'd1 << 35) / 64'd12),
    32'((64'd1 << 32) / 64'd2)
  };

  // Configuration register indexes.
  localparam logic [2:0] REG_CHORD   = 3'd0;
  localparam logic [2:0] REG_THICK   = 3'd1;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_C_SQRT  = 3'd3;
  localparam logic [2:0] REG_C_LIN   = 3'd4;
  localparam logic [2:0] REG_C_SQ    = 3'd5;
  localparam logic [2:0] REG_C_CUBE  = 3'd6;
  localparam logic [2:0] REG_C_QUART = 3'd7;

  // Sideband that travels with every pipeline stage.
  typedef struct packed {
    logic vld;
    logic err;
    logic upper;
  } tag_t;

  typedef struct packed {
    logic        [30:0] chord;
    logic        [15:0] thick;
    logic        [CNT_W-1:0] count;
    logic signed [31:0] c_sqrt;
    logic signed [31:0] c_lin;
    logic signed [31:0] c_sq;
    logic signed [31:0] c_cube;
    logic signed [31:0] c_quart;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    chord:   31'd65536,
    thick:   16'd7864,
    count:   11'd129,
    c_sqrt:  32'sd79698487,
    c_lin:   -32'sd33822868,
    c_sq:    -32'sd94381907,
    c_cube:  32'sd76316200,
    c_quart: -32'sd27246199
  };

endpackage
`default_nettype wire

/* src/acpg_phase_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per stage: phase = index * 2^32 / divisor.
module acpg_phase_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  acpg_pkg::tag_t             tag_i,
  input  logic [acpg_pkg::IDX_W-1:0] idx_i,
  input  logic [acpg_pkg::CNT_W-1:0] div_i,
  output acpg_pkg::tag_t             tag_o,
  output logic [acpg_pkg::PH_W-1:0]  ph_o
);
  import acpg_pkg::*;

  logic [CNT_W-1:0] rem_r   [PH_W];
  logic [PH_W-1:0]  quo_r   [PH_W];
  tag_t             tag_r   [PH_W];
  logic [CNT_W-1:0] rem_nxt [PH_W];
  logic [PH_W-1:0]  quo_nxt [PH_W];
  logic [CNT_W:0]   trial   [PH_W];
  logic [PH_W-1:0]  quo_in  [PH_W];

  // First stage takes the index itself, later stages shift in a zero bit.
  always_comb begin
    trial[0]  = (CNT_W+1)'(idx_i);
    quo_in[0] = '0;
    for (int j = 1; j < PH_W; j++) begin
      trial[j]  = {rem_r[j-1], 1'b0};
      quo_in[j] = quo_r[j-1];
    end
    for (int j = 0; j < PH_W; j++) begin
      if (trial[j] >= {1'b0, div_i}) begin
        rem_nxt[j] = CNT_W'(trial[j] - {1'b0, div_i});
        quo_nxt[j] = {quo_in[j][PH_W-2:0], 1'b1};
      end else begin
        rem_nxt[j] = trial[j][CNT_W-1:0];
        quo_nxt[j] = {quo_in[j][PH_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PH_W; j++) tag_r[j] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
      for (int j = 1; j < PH_W; j++) tag_r[j] <= tag_r[j-1];
    end
  end

  assign tag_o = tag_r[PH_W-1];
  assign ph_o  = quo_r[PH_W-1];

endmodule
`default_nettype wire

/* src/acpg_cosine.sv */
`default_nettype none
// Fold the phase into the first quadrant, form the angle, run the Horner
// cosine series and produce the chordwise fraction u (Q1.30).
module acpg_cosine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  acpg_pkg::tag_t             tag_i,
  input  logic [acpg_pkg::PH_W-1:0]  ph_i,
  output acpg_pkg::tag_t             tag_o,
  output logic [acpg_pkg::Q30_W-1:0] u_o
);
  import acpg_pkg::*;

  localparam int unsigned HZ = 3 * HORNER_STEPS;
  localparam int unsigned TAGS = HZ + 4;
  localparam logic [PH_W-1:0] HALF_TURN = 33'h0_8000_0000;
  localparam logic [PH_W-1:0] FULL_TURN = 33'h1_0000_0000;

  typedef struct packed {
    logic [31:0]      a2;
    logic [31:0]      n;
    logic [31:0]      qe;
    logic [Q30_W-1:0] c;
    logic             neg;
  } hz_t;

  logic [31:0]      fold_f;
  logic             fold_neg;
  logic [Q30_W-1:0] g_r;
  logic             neg0_r;
  logic [Q30_W-1:0] a_r;
  logic             neg1_r;
  logic [31:0]      a2_r;
  logic             neg2_r;
  logic [62:0]      ang_prod;
  logic [61:0]      sq_prod;
  hz_t              hz_r   [HZ];
  hz_t              hz_in  [HZ];
  hz_t              hz_nxt [HZ];
  logic [62:0]      mul_prod [HORNER_STEPS];
  logic [63:0]      rcp_prod [HORNER_STEPS];
  logic [39:0]      cor_rem  [HORNER_STEPS];
  logic [32:0]      cor_q    [HORNER_STEPS];
  logic [31:0]      u_sum;
  logic [Q30_W-1:0] u_r;
  tag_t             tag_r [TAGS];

  // Fold to a quarter turn; the second quadrant negates the cosine.
  always_comb begin
    fold_f   = (ph_i <= HALF_TURN) ? ph_i[31:0] : 32'(FULL_TURN - ph_i);
    fold_neg = fold_f > 32'(Q30_ONE);
  end

  assign ang_prod = 63'(g_r) * 63'(PI_Q30);
  assign sq_prod  = 62'(a_r) * 62'(a_r);

  // Horner series: multiply, scale by reciprocal, then correct the quotient.
  always_comb begin
    hz_in[0] = '{a2: a2_r, n: '0, qe: '0, c: Q30_ONE, neg: neg2_r};
    for (int s = 1; s < HZ; s++) hz_in[s] = hz_r[s-1];
    for (int k = 0; k < HORNER_STEPS; k++) begin
      hz_nxt[3*k]   = hz_in[3*k];
      mul_prod[k]   = 63'(hz_in[3*k].a2) * 63'(hz_in[3*k].c);
      hz_nxt[3*k].n = mul_prod[k][61:30];

      hz_nxt[3*k+1]    = hz_in[3*k+1];
      rcp_prod[k]      = 64'(hz_in[3*k+1].n) * 64'(HORNER_RECIP[k]);
      hz_nxt[3*k+1].qe = 32'(rcp_prod[k] >> HORNER_SH[k]);

      hz_nxt[3*k+2] = hz_in[3*k+2];
      cor_rem[k]    = 40'(hz_in[3*k+2].n)
                      - 40'(hz_in[3*k+2].qe) * 40'(HORNER_DIV[k]);
      cor_q[k]      = 33'(hz_in[3*k+2].qe)
                      + ((cor_rem[k] >= 40'(HORNER_DIV[k])) ? 33'd1 : 33'd0);
      hz_nxt[3*k+2].c = (cor_q[k] >= 33'(Q30_ONE)) ? '0
                        : Q30_W'(33'(Q30_ONE) - cor_q[k]);
    end
  end

  // Chordwise fraction from the cosine and its quadrant.
  assign u_sum = hz_r[HZ-1].neg ? 32'(Q30_ONE) - 32'(hz_r[HZ-1].c)
                                : 32'(Q30_ONE) + 32'(hz_r[HZ-1].c);

  always_ff @(posedge clk) begin
    if (en) begin
      g_r    <= fold_neg ? Q30_W'(32'h8000_0000 - fold_f) : fold_f[Q30_W-1:0];
      neg0_r <= fold_neg;
      a_r    <= ang_prod[61:31];
      neg1_r <= neg0_r;
      a2_r   <= sq_prod[61:30];
      neg2_r <= neg1_r;
      hz_r   <= hz_nxt;
      u_r    <= u_sum[31:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TAGS; j++) tag_r[j] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
      for (int j = 1; j < TAGS; j++) tag_r[j] <= tag_r[j-1];
    end
  end

  assign tag_o = tag_r[TAGS-1];
  assign u_o   = u_r;

endmodule
`default_nettype wire

/* src/acpg_shape.sv */
`default_nettype none
// Square root of u one bit per stage, with the powers of u and the chordwise
// coordinate formed alongside, then the five polynomial terms and their sum.
module acpg_shape (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  acpg_pkg::cfg_t             cfg_i,
  input  acpg_pkg::tag_t             tag_i,
  input  logic [acpg_pkg::Q30_W-1:0] u_i,
  output acpg_pkg::tag_t             tag_o,
  output logic [31:0]                x_o,
  output logic signed [34:0]         poly_o
);
  import acpg_pkg::*;

  localparam int unsigned SQ = Q30_W;
  localparam int unsigned TAGS = SQ + 3;

  typedef struct packed {
    logic [Q30_W-1:0] u;
    logic [Q30_W-1:0] u2;
    logic [Q30_W-1:0] u3;
    logic [Q30_W-1:0] u4;
    logic [31:0]      x;
    logic [Q30_W-1:0] root;
    logic [61:0]      rem;
  } sq_t;

  sq_t                sq_r   [SQ];
  sq_t                sq_in  [SQ];
  sq_t                sq_nxt [SQ];
  logic [61:0]        delta  [SQ];
  logic [61:0]        pow_prod;
  logic [61:0]        x_prod;
  logic [61:0]        u3_prod;
  logic [61:0]        u4_prod;
  logic signed [31:0] coef   [5];
  logic [Q30_W-1:0]   pw     [5];
  logic [31:0]        cmag   [5];
  logic [62:0]        t_prod [5];
  logic signed [33:0] term_nxt [5];
  logic signed [33:0] term_r [5];
  logic [31:0]        x_t_r;
  logic signed [34:0] s01_r;
  logic signed [34:0] s23_r;
  logic signed [34:0] s4_r;
  logic [31:0]        x_s_r;
  logic signed [34:0] poly_r;
  logic [31:0]        x_p_r;
  tag_t               tag_r [TAGS];

  // Higher powers, one multiplication per stage.
  assign u3_prod = 62'(sq_r[0].u2) * 62'(sq_r[0].u);
  assign u4_prod = 62'(sq_r[1].u3) * 62'(sq_r[1].u);

  // Digit-by-digit root; stages one to three also build x, u^2, u^3, u^4.
  always_comb begin
    sq_in[0] = '{u: u_i, u2: '0, u3: '0, u4: '0, x: '0, root: '0,
                 rem: 62'(u_i) << 30};
    for (int j = 1; j < SQ; j++) sq_in[j] = sq_r[j-1];
    pow_prod = '0;
    x_prod   = '0;
    for (int j = 0; j < SQ; j++) begin
      sq_nxt[j] = sq_in[j];
      delta[j]  = (62'(sq_in[j].root) << (SQ - j)) + (62'd1 << (2 * (SQ - 1 - j)));
      if (sq_in[j].rem >= delta[j]) begin
        sq_nxt[j].rem  = sq_in[j].rem - delta[j];
        sq_nxt[j].root = sq_in[j].root | (Q30_W'(1) << (SQ - 1 - j));
      end
      if (j == 0) begin
        pow_prod        = 62'(sq_in[j].u) * 62'(sq_in[j].u);
        x_prod          = 62'(cfg_i.chord) * 62'(sq_in[j].u);
        sq_nxt[j].u2    = pow_prod[60:30];
        sq_nxt[j].x     = x_prod[61:30];
      end
    end
    sq_nxt[1].u3 = u3_prod[60:30];
    sq_nxt[2].u4 = u4_prod[60:30];
  end

  // Terms are truncated toward zero.
  always_comb begin
    coef[0] = cfg_i.c_sqrt;
    coef[1] = cfg_i.c_lin;
    coef[2] = cfg_i.c_sq;
    coef[3] = cfg_i.c_cube;
    coef[4] = cfg_i.c_quart;
    pw[0]   = sq_r[SQ-1].root;
    pw[1]   = sq_r[SQ-1].u;
    pw[2]   = sq_r[SQ-1].u2;
    pw[3]   = sq_r[SQ-1].u3;
    pw[4]   = sq_r[SQ-1].u4;
    for (int i = 0; i < 5; i++) begin
      cmag[i]     = coef[i][31] ? 32'(-coef[i]) : 32'(coef[i]);
      t_prod[i]   = 63'(cmag[i]) * 63'(pw[i]);
      term_nxt[i] = coef[i][31] ? -$signed({1'b0, t_prod[i][62:30]})
                                : $signed({1'b0, t_prod[i][62:30]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQ; j++) sq_r[j] <= sq_nxt[j];
      term_r <= term_nxt;
      x_t_r  <= sq_r[SQ-1].x;
      s01_r  <= 35'(term_r[0]) + 35'(term_r[1]);
      s23_r  <= 35'(term_r[2]) + 35'(term_r[3]);
      s4_r   <= 35'(term_r[4]);
      x_s_r  <= x_t_r;
      poly_r <= s01_r + s23_r + s4_r;
      x_p_r  <= x_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TAGS; j++) tag_r[j] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
      for (int j = 1; j < TAGS; j++) tag_r[j] <= tag_r[j-1];
    end
  end

  assign tag_o  = tag_r[TAGS-1];
  assign x_o    = x_p_r;
  assign poly_o = poly_r;

endmodule
`default_nettype wire

/* src/airfoil_contour_point_generator_unit.sv */
`default_nettype none
`include "airfoil_contour_point_generator_unit_assert.svh"
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   in_point_index
// out_      output     out_valid/out_stall out_x_coord, out_y_coord, out_index_error
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low; its result reaches the
// output register through 94 register stages: the 33-stage phase divider, 25
// cosine stages, the 31-stage square root with 3 sum stages, the scale stage and
// the output register.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// airfoil; cfg_ready is always high.
// A stalled output keeps one more result in a skid register; only then does
// in_stall rise, and the whole pipeline holds until the skid drains.
module airfoil_contour_point_generator_unit #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_point_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_coord,
  output logic signed [31:0] out_y_coord,
  output logic               out_index_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import acpg_pkg::*;

  localparam int unsigned MAX_CLIP = (MAX_POINTS > 2047) ? 2047 : MAX_POINTS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CLIP);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        err;
  } res_t;

  cfg_t             cfg_r;
  logic [46:0]      tc_r;
  logic [49:0]      kk_r;
  logic             en;
  logic [CNT_W-1:0] neff;
  logic [CNT_W-1:0] divisor;
  tag_t             tag_in;
  tag_t             div_tag;
  logic [PH_W-1:0]  div_ph;
  tag_t             cos_tag;
  logic [Q30_W-1:0] cos_u;
  tag_t             shp_tag;
  logic [31:0]      shp_x;
  logic signed [34:0] shp_poly;
  logic [33:0]      pmag;
  logic [58:0]      fa_r;
  logic [58:0]      fb_r;
  logic             fneg_r;
  logic [31:0]      fx_r;
  tag_t             ftag_r;
  logic [59:0]      low;
  logic [41:0]      mag_sum;
  logic [30:0]      mag;
  res_t             res_nxt;
  res_t             out_res_r;
  res_t             skid_res_r;
  logic             out_vld_r;
  logic             skid_vld_r;
  logic             new_vld;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHORD:   cfg_r.chord   <= cfg_data[30:0];
        REG_THICK:   cfg_r.thick   <= cfg_data[15:0];
        REG_COUNT:   cfg_r.count   <= cfg_data[CNT_W-1:0];
        REG_C_SQRT:  cfg_r.c_sqrt  <= cfg_data;
        REG_C_LIN:   cfg_r.c_lin   <= cfg_data;
        REG_C_SQ:    cfg_r.c_sq    <= cfg_data;
        REG_C_CUBE:  cfg_r.c_cube  <= cfg_data;
        REG_C_QUART: cfg_r.c_quart <= cfg_data;
        default: ;
      endcase
    end
  end

  // Thickness scale 5 * t * chord, refreshed every cycle from the registers.
  always_ff @(posedge clk) begin
    tc_r <= 47'(cfg_r.thick) * 47'(cfg_r.chord);
    kk_r <= 50'({tc_r, 2'b00}) + 50'(tc_r);
  end

  // Effective count, divisor and index classification at entry.
  always_comb begin
    neff         = (cfg_r.count < MAX_CNT) ? cfg_r.count : MAX_CNT;
    divisor      = (neff >= CNT_W'(2)) ? neff - CNT_W'(1) : CNT_W'(1);
    tag_in.vld   = in_valid;
    tag_in.err   = CNT_W'(in_point_index) >= neff;
    tag_in.upper = CNT_W'(in_point_index) >= (neff >> 1);
  end

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  acpg_phase_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_in),
    .idx_i (in_point_index),
    .div_i (divisor),
    .tag_o (div_tag),
    .ph_o  (div_ph)
  );

  acpg_cosine u_cos (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (div_tag),
    .ph_i  (div_ph),
    .tag_o (cos_tag),
    .u_o   (cos_u)
  );

  acpg_shape u_shape (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg_i  (cfg_r),
    .tag_i  (cos_tag),
    .u_i    (cos_u),
    .tag_o  (shp_tag),
    .x_o    (shp_x),
    .poly_o (shp_poly)
  );

  // Scale stage: the 34 x 50 product is split into two partial products.
  assign pmag = shp_poly[34] ? 34'(-shp_poly) : 34'(shp_poly);

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r   <= 59'(pmag) * 59'(kk_r[49:25]);
      fb_r   <= 59'(pmag) * 59'(kk_r[24:0]);
      fneg_r <= shp_poly[34] == shp_tag.upper;
      fx_r   <= shp_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ftag_r <= '0;
    end else if (en) begin
      ftag_r <= shp_tag;
    end
  end

  // Recombine, shift by 44, saturate and apply the side sign.
  always_comb begin
    low     = 60'({fa_r[18:0], 25'b0}) + 60'(fb_r);
    mag_sum = 42'(fa_r[58:19]) + 42'(low[59:44]);
    mag     = (mag_sum > 42'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : mag_sum[30:0];
    if (ftag_r.err) begin
      res_nxt = '{x: '0, y: '0, err: 1'b1};
    end else begin
      res_nxt.x   = fx_r;
      res_nxt.y   = fneg_r ? -{1'b0, mag} : {1'b0, mag};
      res_nxt.err = 1'b0;
    end
  end

  // Output register with a one-entry skid behind it.
  assign new_vld = en && ftag_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r  <= skid_vld_r || new_vld;
      skid_vld_r <= 1'b0;
    end else if (new_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || !out_stall) begin
      out_res_r <= skid_vld_r ? skid_res_r : res_nxt;
    end else if (new_vld) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_x_coord     = out_res_r.x;
  assign out_y_coord     = out_res_r.y;
  assign out_index_error = out_res_r.err;

  // The skid only holds a result while the output register is occupied.
  `ACPG_ASSERT_SAME(a_skid_behind_out, skid_vld_r, out_vld_r, "skid full with empty output")
  // An index error carries zero coordinates.
  `ACPG_ASSERT_SAME(a_err_zero, out_valid && out_index_error,
                    out_x_coord == 32'sd0 && out_y_coord == 32'sd0, "error result not zero")
  // The thickness magnitude saturates short of the most negative code.
  `ACPG_ASSERT_SAME(a_y_sat, out_valid, out_y_coord != 32'sh8000_0000, "y outside saturation")
  // A held output with a new result arriving fills the skid.
  `ACPG_ASSERT_NEXT(a_skid_fill, out_vld_r && out_stall && new_vld, skid_vld_r, "skid missed result")

endmodule
`default_nettype wire
